// ----- rtl/core/iir_direct_form_one_filter_core_defines.svh -----
// Assertion macros shared by the filter core checker.
// No dependencies; included by files that assert.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_CORE_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset
`define IIRDF1_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define IIRDF1_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/iirdf1_pkg.sv -----
// Package for the direct form I filter core: sizes, codes, beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iirdf1_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int HA_W        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CA_W        = $clog2(MAX_ORDER + 1);
    localparam int DCNT_W      = $clog2(SAMPLE_BITS + 1);

    typedef enum logic [1:0] {
        FN_FILTER = 2'd0,
        FN_WR_NUM = 2'd1,
        FN_WR_DEN = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_A0_ZERO   = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef struct packed {
        t_func                         func;
        logic [3:0]                    coef_index;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        t_status                       status;
    } t_out;

    typedef struct packed {
        logic            rd_en;
        logic [HA_W-1:0] rd_k;
        logic            push;
        logic            clear;
    } t_hist_ctl;

    typedef struct packed {
        logic            rd_en;
        logic [CA_W-1:0] rd_idx;
        logic            wr_en;
        logic            wr_den;
        logic [CA_W-1:0] wr_idx;
    } t_coef_ctl;

    typedef enum logic [3:0] {
        S_IDLE, S_A0, S_RD, S_MB, S_MA, S_SA, S_MX, S_SX, S_DS, S_DIV, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE, D_CHK, D_ITER, D_FIN
    } t_div_state;

    // Saturating signed add, as wide as the accumulator
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/iirdf1_hist_mem.sv -----
// Sample history memory: circular buffer of {input, output} pairs.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iirdf1_hist_mem (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire iirdf1_pkg::t_hist_ctl                   i_ctl,
    input  wire logic signed [iirdf1_pkg::SAMPLE_BITS-1:0] i_push_u,
    input  wire logic signed [iirdf1_pkg::SAMPLE_BITS-1:0] i_push_y,
    output logic signed [iirdf1_pkg::SAMPLE_BITS-1:0]     o_u,
    output logic signed [iirdf1_pkg::SAMPLE_BITS-1:0]     o_y
);
    localparam int S = iirdf1_pkg::SAMPLE_BITS;
    localparam int D = iirdf1_pkg::MAX_ORDER;
    localparam int A = iirdf1_pkg::HA_W;

    logic [2*S-1:0] mem [D];
    logic [D-1:0]   r_valid;
    logic [A-1:0]   r_head;
    logic [A-1:0]   rd_slot;
    logic [A-1:0]   new_slot;
    logic [A:0]     slot_sum;
    logic [2*S-1:0] r_rd_data;
    logic           r_rd_vld;

    // newest entry sits at the head; older ones follow it
    assign slot_sum = {1'b0, r_head} + {1'b0, i_ctl.rd_k};
    assign rd_slot  = (slot_sum >= (A+1)'(D)) ? A'(slot_sum - (A+1)'(D)) : slot_sum[A-1:0];
    assign new_slot = (r_head == '0) ? A'(D - 1) : r_head - A'(1);

    // head and valid bits; a clear drops every entry at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.push) begin
            r_valid[new_slot] <= 1'b1;
            r_head            <= new_slot;
        end
    end

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push)
            mem[new_slot] <= {i_push_u, i_push_y};
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[rd_slot];
            r_rd_vld  <= r_valid[rd_slot];
        end
    end

    // never-written entries read as zero
    assign o_u = r_rd_vld ? r_rd_data[2*S-1:S] : '0;
    assign o_y = r_rd_vld ? r_rd_data[S-1:0]   : '0;

endmodule
`default_nettype wire

// ----- rtl/core/iirdf1_coef_mem.sv -----
// Coefficient memory: one {numerator, denominator} pair per index.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iirdf1_coef_mem (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire iirdf1_pkg::t_coef_ctl                   i_ctl,
    input  wire logic signed [iirdf1_pkg::COEF_BITS-1:0] i_wr_data,
    output logic signed [iirdf1_pkg::COEF_BITS-1:0]      o_b,
    output logic signed [iirdf1_pkg::COEF_BITS-1:0]      o_a
);
    localparam int C = iirdf1_pkg::COEF_BITS;
    localparam int D = iirdf1_pkg::MAX_ORDER + 1;

    logic [2*C-1:0] mem [D];
    logic [D-1:0]   r_bv;
    logic [D-1:0]   r_av;
    logic [2*C-1:0] r_rd_data;
    logic           r_rd_bv;
    logic           r_rd_av;

    // per-half valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_av <= '0;
        end else if (i_ctl.wr_en) begin
            if (i_ctl.wr_den) r_av[i_ctl.wr_idx] <= 1'b1;
            else              r_bv[i_ctl.wr_idx] <= 1'b1;
        end
    end

    // half-word writes, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            if (i_ctl.wr_den) mem[i_ctl.wr_idx][C-1:0]   <= i_wr_data;
            else              mem[i_ctl.wr_idx][2*C-1:C] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_ctl.rd_idx];
            r_rd_bv   <= r_bv[i_ctl.rd_idx];
            r_rd_av   <= r_av[i_ctl.rd_idx];
        end
    end

    assign o_b = r_rd_bv ? r_rd_data[2*C-1:C] : '0;
    assign o_a = r_rd_av ? r_rd_data[C-1:0]   : '0;

endmodule
`default_nettype wire

// ----- rtl/core/iirdf1_divider.sv -----
// Serial signed divider, one quotient bit a cycle, saturating result.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iirdf1_divider (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_start,
    input  wire logic signed [iirdf1_pkg::ACC_W-1:0]       i_num,
    input  wire logic signed [iirdf1_pkg::COEF_BITS-1:0]   i_den,
    output logic                                           o_done,
    output logic signed [iirdf1_pkg::SAMPLE_BITS-1:0]      o_q
);
    localparam int S = iirdf1_pkg::SAMPLE_BITS;
    localparam int C = iirdf1_pkg::COEF_BITS;
    localparam int W = iirdf1_pkg::ACC_W;
    localparam int N = iirdf1_pkg::DCNT_W;

    iirdf1_pkg::t_div_state r_state, n_state;

    logic [W-1:0]   r_un;
    logic [C-1:0]   r_ud;
    logic           r_neg;
    logic [C-1:0]   r_rem;
    logic [S-1:0]   r_sh;
    logic [S-1:0]   r_q;
    logic [N-1:0]   r_cnt;
    logic           sat;
    logic [C:0]     trial;
    logic           qbit;
    logic           last;

    // quotient would not fit the sample width at all
    assign sat   = {1'b0, r_un} >= ((W+1)'(r_ud) << S);
    assign trial = {r_rem, r_sh[S-1]};
    assign qbit  = trial >= {1'b0, r_ud};
    assign last  = r_cnt == N'(S - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iirdf1_pkg::D_IDLE: if (i_start) n_state = iirdf1_pkg::D_CHK;
            iirdf1_pkg::D_CHK:  n_state = sat ? iirdf1_pkg::D_FIN : iirdf1_pkg::D_ITER;
            iirdf1_pkg::D_ITER: if (last) n_state = iirdf1_pkg::D_FIN;
            iirdf1_pkg::D_FIN:  n_state = iirdf1_pkg::D_IDLE;
            default:            n_state = iirdf1_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= iirdf1_pkg::D_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            iirdf1_pkg::D_IDLE: begin
                r_un  <= i_num[W-1] ? W'(0) - W'(i_num) : W'(i_num);
                r_ud  <= i_den[C-1] ? C'(0) - C'(i_den) : C'(i_den);
                r_neg <= i_num[W-1] ^ i_den[C-1];
            end
            iirdf1_pkg::D_CHK: begin
                r_q   <= sat ? '1 : '0;
                r_rem <= r_un[C+S-1:S];
                r_sh  <= r_un[S-1:0];
                r_cnt <= '0;
            end
            iirdf1_pkg::D_ITER: begin
                r_rem <= qbit ? C'(trial - {1'b0, r_ud}) : trial[C-1:0];
                r_sh  <= {r_sh[S-2:0], 1'b0};
                r_q   <= {r_q[S-2:0], qbit};
                r_cnt <= r_cnt + N'(1);
            end
            default: ;
        endcase
    end

    // sign and clamp to the sample range
    always_comb begin
        o_done = r_state == iirdf1_pkg::D_FIN;
        if (r_neg)
            o_q = (r_q > {1'b1, {(S-1){1'b0}}}) ? {1'b1, {(S-1){1'b0}}} : S'(0) - r_q;
        else
            o_q = (r_q > {1'b0, {(S-1){1'b1}}}) ? {1'b0, {(S-1){1'b1}}} : r_q;
    end

endmodule
`default_nettype wire

// ----- rtl/core/iir_direct_form_one_filter_core.sv -----
// Top level of the direct form I filter core: sequencer, MAC, APB register.
// Depends on iirdf1_pkg, iirdf1_hist_mem, iirdf1_coef_mem, iirdf1_divider.
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+---------------------------
//   in       | in        | i_in_valid / o_in_stall | t_in: func, index, value
//   out      | out       | o_out_valid / i_out_stall | t_out: filtered, status
//   cfg      | in        | APB psel/penable/pready | filter_order at byte 0
//
// A sample beat steps through S_RD, S_MB, S_MA and S_SA for each history
// tap, through the one shared multiplier and memory read port, then through
// the divider one quotient bit at a time. A zero a0 goes from S_A0 to S_DONE.
// Coefficient writes and clears finish in the cycle they are accepted.
// Reset is synchronous; memories need no clearing pass, valid bits do it.
// The result register holds while o_out_valid is stalled.
`timescale 1ns / 1ps
`default_nettype none
module iir_direct_form_one_filter_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire iirdf1_pkg::t_in   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output iirdf1_pkg::t_out       o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int S  = iirdf1_pkg::SAMPLE_BITS;
    localparam int C  = iirdf1_pkg::COEF_BITS;
    localparam int W  = iirdf1_pkg::ACC_W;
    localparam int P  = iirdf1_pkg::PROD_W;
    localparam int CA = iirdf1_pkg::CA_W;
    localparam int HA = iirdf1_pkg::HA_W;
    localparam int M  = iirdf1_pkg::MAX_ORDER;

    iirdf1_pkg::t_state    r_state, n_state;
    iirdf1_pkg::t_hist_ctl hist_ctl;
    iirdf1_pkg::t_coef_ctl coef_ctl;
    iirdf1_pkg::t_out      r_out, r_res;

    logic [3:0]           r_order;
    logic [CA-1:0]        eff_n;
    logic [CA-1:0]        r_k;
    logic signed [S-1:0]  r_x;
    logic signed [C-1:0]  r_b0;
    logic signed [C-1:0]  r_a0;
    logic signed [W-1:0]  r_acc;
    logic signed [W-1:0]  r_prod;
    logic                 r_ov;
    logic signed [S-1:0]  hist_u, hist_y;
    logic signed [C-1:0]  coef_b, coef_a;
    logic signed [S-1:0]  mul_s;
    logic signed [C-1:0]  mul_c;
    logic signed [P-1:0]  prod;
    logic                 div_start, div_done;
    logic signed [S-1:0]  div_q;
    logic                 accept, slot_free, load_idle, load_done;
    logic                 is_wr, bad_idx;
    logic [CA+3:0]        idx_ext;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, r_order} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_order <= 4'd1;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            r_order <= pwdata[3:0];
    end

    assign eff_n = (int'(r_order) > M) ? CA'(M) : CA'(r_order);

    // input handshake
    assign slot_free  = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != iirdf1_pkg::S_IDLE)
                     || (i_in_data.func != iirdf1_pkg::FN_FILTER && !slot_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign is_wr      = i_in_data.func == iirdf1_pkg::FN_WR_NUM
                     || i_in_data.func == iirdf1_pkg::FN_WR_DEN;
    assign bad_idx    = int'(i_in_data.coef_index) > M;
    assign idx_ext    = {{CA{1'b0}}, i_in_data.coef_index};
    assign load_idle  = accept && i_in_data.func != iirdf1_pkg::FN_FILTER;
    assign load_done  = r_state == iirdf1_pkg::S_DONE && slot_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iirdf1_pkg::S_IDLE:
                if (accept && i_in_data.func == iirdf1_pkg::FN_FILTER)
                    n_state = iirdf1_pkg::S_A0;
            iirdf1_pkg::S_A0:
                if (coef_a == '0)       n_state = iirdf1_pkg::S_DONE;
                else if (eff_n == '0)   n_state = iirdf1_pkg::S_MX;
                else                    n_state = iirdf1_pkg::S_RD;
            iirdf1_pkg::S_RD:  n_state = iirdf1_pkg::S_MB;
            iirdf1_pkg::S_MB:  n_state = iirdf1_pkg::S_MA;
            iirdf1_pkg::S_MA:  n_state = iirdf1_pkg::S_SA;
            iirdf1_pkg::S_SA:
                n_state = (r_k + CA'(1) == eff_n) ? iirdf1_pkg::S_MX : iirdf1_pkg::S_RD;
            iirdf1_pkg::S_MX:  n_state = iirdf1_pkg::S_SX;
            iirdf1_pkg::S_SX:  n_state = iirdf1_pkg::S_DS;
            iirdf1_pkg::S_DS:  n_state = iirdf1_pkg::S_DIV;
            iirdf1_pkg::S_DIV: if (div_done) n_state = iirdf1_pkg::S_DONE;
            iirdf1_pkg::S_DONE: if (slot_free) n_state = iirdf1_pkg::S_IDLE;
            default: n_state = iirdf1_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= iirdf1_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // memory and divider controls
    always_comb begin
        hist_ctl.rd_en  = r_state == iirdf1_pkg::S_RD;
        hist_ctl.rd_k   = r_k[HA-1:0];
        hist_ctl.push   = r_state == iirdf1_pkg::S_DIV && div_done;
        hist_ctl.clear  = accept && i_in_data.func == iirdf1_pkg::FN_CLEAR;
        coef_ctl.rd_en  = (r_state == iirdf1_pkg::S_IDLE) || (r_state == iirdf1_pkg::S_RD);
        coef_ctl.rd_idx = (r_state == iirdf1_pkg::S_RD) ? r_k + CA'(1) : '0;
        coef_ctl.wr_en  = accept && is_wr && !bad_idx;
        coef_ctl.wr_den = i_in_data.func == iirdf1_pkg::FN_WR_DEN;
        coef_ctl.wr_idx = idx_ext[CA-1:0];
        div_start       = r_state == iirdf1_pkg::S_DS;
    end

    // shared multiplier operands
    always_comb begin
        case (r_state)
            iirdf1_pkg::S_MB: begin mul_s = hist_u; mul_c = coef_b; end
            iirdf1_pkg::S_MA: begin mul_s = hist_y; mul_c = coef_a; end
            default:          begin mul_s = r_x;    mul_c = r_b0;   end
        endcase
    end
    assign prod = mul_s * mul_c;

    // accumulate datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            iirdf1_pkg::S_IDLE: r_x <= i_in_data.value;
            iirdf1_pkg::S_A0: begin
                r_b0  <= coef_b;
                r_a0  <= coef_a;
                r_acc <= '0;
                r_k   <= '0;
                r_res <= '{filtered: '0, status: iirdf1_pkg::ST_A0_ZERO};
            end
            iirdf1_pkg::S_MB: r_prod <= W'(prod);
            iirdf1_pkg::S_MA: begin
                r_acc  <= iirdf1_pkg::sat_add(r_acc, r_prod);
                r_prod <= W'(prod);
            end
            iirdf1_pkg::S_SA: begin
                r_acc <= iirdf1_pkg::sat_add(r_acc, -r_prod);
                r_k   <= r_k + CA'(1);
            end
            iirdf1_pkg::S_MX: r_prod <= W'(prod);
            iirdf1_pkg::S_SX: r_acc  <= iirdf1_pkg::sat_add(r_acc, r_prod);
            iirdf1_pkg::S_DIV:
                if (div_done) r_res <= '{filtered: div_q, status: iirdf1_pkg::ST_OK};
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (load_idle || load_done)
            r_ov <= 1'b1;
        else if (!i_out_stall)
            r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load_idle)
            r_out <= '{filtered: '0,
                       status: (is_wr && bad_idx) ? iirdf1_pkg::ST_BAD_INDEX
                                                  : iirdf1_pkg::ST_OK};
        else if (load_done)
            r_out <= r_res;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    iirdf1_hist_mem u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (hist_ctl),
        .i_push_u (r_x),
        .i_push_y (div_q),
        .o_u      (hist_u),
        .o_y      (hist_y)
    );

    iirdf1_coef_mem u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (coef_ctl),
        .i_wr_data (i_in_data.value),
        .o_b       (coef_b),
        .o_a       (coef_a)
    );

    iirdf1_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_a0),
        .o_done  (div_done),
        .o_q     (div_q)
    );

endmodule
`default_nettype wire

// ----- rtl/core/iirdf1_checker.sv -----
// Port-level checker for the filter core, bound to the top level.
// Depends on iirdf1_pkg and iir_direct_form_one_filter_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "iir_direct_form_one_filter_core_defines.svh"
module iirdf1_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire iirdf1_pkg::t_in  i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire iirdf1_pkg::t_out o_out_data
);
    // no beat survives reset
    `IIRDF1_ASSERT_ALWAYS(a_rst_empty, !i_rst_n, !o_out_valid, "result valid after reset")

    // a stalled result stays offered
    `IIRDF1_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    // error results carry no sample
    `IIRDF1_ASSERT_NOW(a_err_zero,
        o_out_valid && o_out_data.status != iirdf1_pkg::ST_OK,
        o_out_data.filtered == '0, "error result with nonzero output")

    // coefficient writes and clears answer in the next cycle
    `IIRDF1_ASSERT_NEXT(a_cmd_fast,
        i_in_valid && !o_in_stall && i_in_data.func != iirdf1_pkg::FN_FILTER,
        o_out_valid, "command beat gave no result")

    // a sample keeps the input closed while it is worked on
    `IIRDF1_ASSERT_NEXT(a_busy,
        i_in_valid && !o_in_stall && i_in_data.func == iirdf1_pkg::FN_FILTER,
        o_in_stall, "input open during sample work")

endmodule

bind iir_direct_form_one_filter_core iirdf1_checker u_chk (.*);
`default_nettype wire

// ----- dv/iir_direct_form_one_filter_core_tb.sv -----
// Self-checking bench for the direct form I filter core: directed table, then random beats.
// Depends on iirdf1_pkg and iir_direct_form_one_filter_core.
`timescale 1ns / 1ps
module iir_direct_form_one_filter_core_tb;

    localparam int MAX_ORDER = iirdf1_pkg::MAX_ORDER;
    localparam int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS;
    localparam logic [2:0] ORDER_ADDR = 3'd0;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 175;
    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [23:0] ONE_Q20 = 24'sd1048576;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    iirdf1_pkg::t_in  i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    iirdf1_pkg::t_out o_out_data;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    iir_direct_form_one_filter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow state of the filter
    logic [3:0] shadow_order;
    longint     past_in [MAX_ORDER];
    longint     past_out [MAX_ORDER];
    longint     num_coef [MAX_ORDER + 1];
    longint     den_coef [MAX_ORDER + 1];

    iirdf1_pkg::t_out pending_results [$];
    int   err_cnt;
    int   idle_mode;
    int   hold_req;
    int   quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint acc_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    // Filter one beat in the shadow state and return its result
    function automatic iirdf1_pkg::t_out filter_beat(iirdf1_pkg::t_in b);
        iirdf1_pkg::t_out r;
        longint x, acc, q;
        int     n;
        r.filtered = '0;
        r.status = iirdf1_pkg::ST_OK;
        case (b.func)
            iirdf1_pkg::FN_WR_NUM, iirdf1_pkg::FN_WR_DEN: begin
                if (b.coef_index > MAX_ORDER) r.status = iirdf1_pkg::ST_BAD_INDEX;
                else if (b.func == iirdf1_pkg::FN_WR_NUM) num_coef[b.coef_index] = b.value;
                else den_coef[b.coef_index] = b.value;
            end
            iirdf1_pkg::FN_CLEAR: begin
                for (int i = 0; i < MAX_ORDER; i++) begin
                    past_in[i] = 0;
                    past_out[i] = 0;
                end
            end
            default: begin
                x = b.value;
                if (den_coef[0] == 0) begin
                    r.status = iirdf1_pkg::ST_A0_ZERO;
                end else begin
                    n = (shadow_order > MAX_ORDER) ? MAX_ORDER : shadow_order;
                    acc = 0;
                    for (int i = 0; i < n; i++) begin
                        acc = acc_add(acc, past_in[i] * num_coef[i + 1]);
                        acc = acc_add(acc, -(past_out[i] * den_coef[i + 1]));
                    end
                    acc = acc_add(acc, x * num_coef[0]);
                    q = acc / den_coef[0];
                    if (q > OUT_MAX) q = OUT_MAX;
                    if (q < OUT_MIN) q = OUT_MIN;
                    for (int i = MAX_ORDER - 1; i > 0; i--) begin
                        past_in[i] = past_in[i - 1];
                        past_out[i] = past_out[i - 1];
                    end
                    past_in[0] = x;
                    past_out[0] = q;
                    r.filtered = q[SAMPLE_BITS-1:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic bit roll_idle(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Offer one beat; caller stands at a falling edge and returns at one
    task automatic send_beat(iirdf1_pkg::t_in b, bit typed, iirdf1_pkg::t_out want);
        iirdf1_pkg::t_out got;
        while (roll_idle(idle_mode == 0 ? 29 : (idle_mode == 1 ? 83 : 0))) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        got = filter_beat(b);
        pending_results.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    task automatic write_order(logic [3:0] ord);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ORDER_ADDR; pwdata <= {28'd0, ord};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_order = ord;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait for all results, then let the core settle before a register write
    task automatic drain_and_settle();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic iirdf1_pkg::t_in random_beat();
        iirdf1_pkg::t_in b;
        int  r;
        r = $urandom_range(0, 99);
        b.coef_index = 4'($urandom_range(0, 15));
        b.value = 24'($urandom);
        if (r < 70) begin
            b.func = iirdf1_pkg::FN_FILTER;
            if ($urandom_range(0, 1))
                b.value = 24'($signed($urandom_range(0, 131072)) - 65536);
        end else if (r < 92) begin
            b.func = $urandom_range(0, 1) ? iirdf1_pkg::FN_WR_NUM : iirdf1_pkg::FN_WR_DEN;
            if ($urandom_range(0, 9) != 0) b.coef_index = 4'($urandom_range(0, MAX_ORDER));
            if (b.func == iirdf1_pkg::FN_WR_DEN && b.coef_index == 0) begin
                r = $urandom_range(0, 19);
                if (r == 0) b.value = '0;
                else if (r > 3)
                    b.value = 24'(ONE_Q20 + $signed($urandom_range(0, 131072)) - 65536);
            end else if ($urandom_range(0, 9) < 7) begin
                b.value = 24'($signed($urandom_range(0, 524288)) - 262144);
            end
        end else begin
            b.func = iirdf1_pkg::FN_CLEAR;
        end
        return b;
    endfunction

    // Receiver stall, with a long hold-off on request
    initial begin
        int hold_cnt;
        int seen_req;
        hold_cnt = 0;
        seen_req = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= roll_idle(idle_mode == 0 ? 83 : (idle_mode == 1 ? 29 : 0));
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        iirdf1_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: filtered %0d status %0d",
                       o_out_data.filtered, o_out_data.status);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered,
                           o_out_data.filtered);
                    err_cnt++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Directed table: func, index, value, typed check, filtered, status
    typedef struct {
        iirdf1_pkg::t_func   func;
        logic [3:0]          idx;
        logic signed [23:0]  value;
        bit                  typed;
        logic signed [23:0]  filtered;
        iirdf1_pkg::t_status status;
    } t_row;

    t_row rows [] = '{
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sh123456, 1, 24'sd0, iirdf1_pkg::ST_A0_ZERO},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sh7fffff, 1, 24'sd0, iirdf1_pkg::ST_A0_ZERO},
        '{iirdf1_pkg::FN_WR_NUM, 4'd9, 24'sd5, 1, 24'sd0, iirdf1_pkg::ST_BAD_INDEX},
        '{iirdf1_pkg::FN_WR_DEN, 4'd15, 24'sh800000, 1, 24'sd0, iirdf1_pkg::ST_BAD_INDEX},
        '{iirdf1_pkg::FN_WR_DEN, 4'd0, ONE_Q20, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_NUM, 4'd0, ONE_Q20, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sh7fffff, 1, 24'sh7fffff, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sh800000, 1, 24'sh800000, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_NUM, 4'd1, 24'sd524288, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_DEN, 4'd1, -24'sd262144, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd65536, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd0, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, -24'sd65536, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_CLEAR, 4'd0, 24'sd0, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd65536, 1, 24'sd65536, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_DEN, 4'd0, 24'sd1, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd100, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, -24'sd100, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_NUM, 4'd8, 24'sh7fffff, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_DEN, 4'd8, 24'sh800000, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_DEN, 4'd0, -ONE_Q20, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd12345, 0, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_WR_DEN, 4'd0, 24'sd0, 1, 24'sd0, iirdf1_pkg::ST_OK},
        '{iirdf1_pkg::FN_FILTER, 4'd0, 24'sd5, 1, 24'sd0, iirdf1_pkg::ST_A0_ZERO},
        '{iirdf1_pkg::FN_WR_DEN, 4'd0, ONE_Q20, 1, 24'sd0, iirdf1_pkg::ST_OK}
    };

    logic [3:0] phase_order [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd1};

    // Main sequence
    initial begin
        iirdf1_pkg::t_in  b;
        iirdf1_pkg::t_out want;
        err_cnt = 0;
        idle_mode = 2;
        hold_req = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        shadow_order = 4'd1;
        for (int i = 0; i < MAX_ORDER; i++) begin
            past_in[i] = 0;
            past_out[i] = 0;
        end
        for (int i = 0; i <= MAX_ORDER; i++) begin
            num_coef[i] = 0;
            den_coef[i] = 0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset order
        foreach (rows[k]) begin
            b.func = rows[k].func;
            b.coef_index = rows[k].idx;
            b.value = rows[k].value;
            want.filtered = rows[k].filtered;
            want.status = rows[k].status;
            send_beat(b, rows[k].typed, want);
        end
        i_in_valid <= 1'b0;
        drain_and_settle();

        // Random phases across orders and idling patterns
        for (int p = 0; p < 6; p++) begin
            idle_mode = p / 2;
            write_order(p == 5 ? 4'($urandom_range(1, MAX_ORDER)) : phase_order[p]);
            @(negedge i_clk);
            if (p == 1 || p == 4) hold_req++;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (p == 3 && k == PHASE_BEATS / 2) begin
                    i_in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                send_beat(random_beat(), 0, want);
            end
            i_in_valid <= 1'b0;
            drain_and_settle();
        end

        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- iir_direct_form_one_filter_core.f -----
+incdir+rtl/core
rtl/core/iirdf1_pkg.sv
rtl/core/iirdf1_hist_mem.sv
rtl/core/iirdf1_coef_mem.sv
rtl/core/iirdf1_divider.sv
rtl/core/iir_direct_form_one_filter_core.sv
rtl/core/iirdf1_checker.sv
dv/iir_direct_form_one_filter_core_tb.sv
